// ===== hw/rtl/mrpt_pkg.sv =====
// Package with shared types, constants and the witness tables for the primality tester.
package mrpt_pkg;

  localparam int unsigned NumW = 63;
  localparam int unsigned SumW = NumW + 1;
  localparam int unsigned WitW = 31;
  localparam logic [NumW-1:0] SmallLimit = 63'd4759123141;
  localparam logic [2:0] SmallCnt = 3'd3;
  localparam logic [2:0] LargeCnt = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STRIP,
    ST_RED,
    ST_RED_W,
    ST_PCHK,
    ST_PMUL_W,
    ST_PSQ_W,
    ST_SQCHK,
    ST_SQ_W,
    ST_WEND,
    ST_OUT
  } mrpt_state_t;

  function automatic logic [WitW-1:0] witness(input logic use_large, input logic [2:0] idx);
    logic [WitW-1:0] w;
    w = '0;
    if (!use_large) begin
      case (idx)
        3'd0: w = 31'd2;
        3'd1: w = 31'd7;
        3'd2: w = 31'd61;
        default: w = 31'd2;
      endcase
    end else begin
      case (idx)
        3'd0: w = 31'd2;
        3'd1: w = 31'd325;
        3'd2: w = 31'd9375;
        3'd3: w = 31'd28178;
        3'd4: w = 31'd450775;
        3'd5: w = 31'd9780504;
        3'd6: w = 31'd1795265022;
        default: w = 31'd2;
      endcase
    end
    return w;
  endfunction

endpackage

// ===== hw/rtl/mrpt_mulmod.sv =====
// Bit-serial modular multiplier: one conditional add and one doubling per cycle.
module mrpt_mulmod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mrpt_pkg::NumW-1:0] x_in,
  input  logic [mrpt_pkg::NumW-1:0] y_in,
  input  logic [mrpt_pkg::NumW-1:0] n,
  output logic                      done,
  output logic [mrpt_pkg::NumW-1:0] result
);
  import mrpt_pkg::*;

  logic            busy_r, busy_nxt;
  logic [NumW-1:0] x_r, x_nxt;
  logic [NumW-1:0] y_r, y_nxt;
  logic [NumW-1:0] acc_r, acc_nxt;
  logic [SumW-1:0] acc_sum;
  logic [SumW-1:0] dbl_sum;
  logic [NumW-1:0] acc_red;
  logic [NumW-1:0] dbl_red;

  always_comb begin
    acc_sum = {1'b0, acc_r} + {1'b0, x_r};
    dbl_sum = {1'b0, x_r} + {1'b0, x_r};
    acc_red = (acc_sum >= {1'b0, n}) ? NumW'(acc_sum - {1'b0, n}) : acc_sum[NumW-1:0];
    dbl_red = (dbl_sum >= {1'b0, n}) ? NumW'(dbl_sum - {1'b0, n}) : dbl_sum[NumW-1:0];
    busy_nxt = busy_r;
    x_nxt = x_r;
    y_nxt = y_r;
    acc_nxt = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      x_nxt = x_in;
      y_nxt = y_in;
      acc_nxt = '0;
    end else if (busy_r) begin
      if (y_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (y_r[0]) begin
          acc_nxt = acc_red;
        end
        x_nxt = dbl_red;
        y_nxt = y_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    acc_r <= acc_nxt;
  end

  assign done = busy_r && (y_r == '0);
  assign result = acc_r;

  a_acc_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (acc_r < n)) else $error("accumulator not reduced");
  a_x_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (x_r < n)) else $error("multiplicand not reduced");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !start) |=> !busy_r) else $error("multiplier stayed busy after done");

endmodule

// ===== hw/rtl/miller_rabin_prime_test_64_unit.sv =====
// Top level of the deterministic Miller-Rabin primality tester for 63-bit values.
//
//  channel | direction | tdata fields (low bit up)     | tuser/tlast
//  in_     | input     | number[62:0], one ignored pad | none
//  out_    | output    | is_prime_flag[0], seven zeros | none
//
// The time an item takes depends on its value: values below three and even values
// go straight to the result after the check, while a large prime runs all 7 witnesses.
// The time is set by the bit-serial modular multiplier, which handles one bit of its
// second operand per cycle, and the stripping of n-1 one bit per cycle.
// Reset clears the sequencer and the output beat; a stalled result holds until taken.
module miller_rabin_prime_test_64_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // number[62:0], pad[63]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // is_prime_flag[0], pad[7:1]
);
  import mrpt_pkg::*;

  mrpt_state_t     state_r, state_nxt;
  logic [NumW-1:0] n_r, n_nxt;
  logic [NumW-1:0] d_r, d_nxt;
  logic [NumW-1:0] e_r, e_nxt;
  logic [NumW-1:0] t_r, t_nxt;
  logic [NumW-1:0] r_r, r_nxt;
  logic [NumW-1:0] base_r, base_nxt;
  logic [2:0]      widx_r, widx_nxt;
  logic            large_r, large_nxt;
  logic            flag_r, flag_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_flag_r, out_flag_nxt;
  logic            mul_start;
  logic [NumW-1:0] mul_x;
  logic [NumW-1:0] mul_y;
  logic            mul_done;
  logic [NumW-1:0] mul_res;
  logic [NumW-1:0] nm1;

  assign nm1 = n_r - NumW'(1);

  mrpt_mulmod u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .x_in   (mul_x),
    .y_in   (mul_y),
    .n      (n_r),
    .done   (mul_done),
    .result (mul_res)
  );

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;
    d_nxt = d_r;
    e_nxt = e_r;
    t_nxt = t_r;
    r_nxt = r_r;
    base_nxt = base_r;
    widx_nxt = widx_r;
    large_nxt = large_r;
    flag_nxt = flag_r;
    out_valid_nxt = out_valid_r;
    out_flag_nxt = out_flag_r;
    mul_start = 1'b0;
    mul_x = base_r;
    mul_y = base_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          n_nxt = in_tdata[NumW-1:0];
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (n_r <= NumW'(1)) begin
          flag_nxt = 1'b0;
          state_nxt = ST_OUT;
        end else if (n_r == NumW'(2)) begin
          flag_nxt = 1'b1;
          state_nxt = ST_OUT;
        end else if (!n_r[0]) begin
          flag_nxt = 1'b0;
          state_nxt = ST_OUT;
        end else begin
          d_nxt = nm1;
          large_nxt = (n_r >= SmallLimit);
          widx_nxt = '0;
          state_nxt = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (d_r[0]) begin
          state_nxt = ST_RED;
        end else begin
          d_nxt = d_r >> 1;
        end
      end
      ST_RED: begin
        mul_start = 1'b1;
        mul_x = NumW'(1);
        mul_y = NumW'(witness(large_r, widx_r));
        state_nxt = ST_RED_W;
      end
      ST_RED_W: begin
        if (mul_done) begin
          if (mul_res == '0) begin
            state_nxt = ST_WEND;
          end else begin
            base_nxt = mul_res;
            r_nxt = NumW'(1);
            e_nxt = d_r;
            state_nxt = ST_PCHK;
          end
        end
      end
      ST_PCHK: begin
        if (e_r == '0) begin
          t_nxt = d_r;
          state_nxt = ST_SQCHK;
        end else if (e_r[0]) begin
          mul_start = 1'b1;
          mul_x = r_r;
          mul_y = base_r;
          state_nxt = ST_PMUL_W;
        end else begin
          mul_start = 1'b1;
          state_nxt = ST_PSQ_W;
        end
      end
      ST_PMUL_W: begin
        if (mul_done) begin
          r_nxt = mul_res;
          mul_start = 1'b1;
          state_nxt = ST_PSQ_W;
        end
      end
      ST_PSQ_W: begin
        if (mul_done) begin
          base_nxt = mul_res;
          e_nxt = e_r >> 1;
          state_nxt = ST_PCHK;
        end
      end
      ST_SQCHK: begin
        if (t_r != nm1 && r_r != NumW'(1) && r_r != nm1) begin
          mul_start = 1'b1;
          mul_x = r_r;
          mul_y = r_r;
          state_nxt = ST_SQ_W;
        end else if (r_r != nm1 && !t_r[0]) begin
          flag_nxt = 1'b0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_WEND;
        end
      end
      ST_SQ_W: begin
        if (mul_done) begin
          r_nxt = mul_res;
          t_nxt = t_r << 1;
          state_nxt = ST_SQCHK;
        end
      end
      ST_WEND: begin
        if (widx_r == (large_r ? LargeCnt : SmallCnt) - 3'd1) begin
          flag_nxt = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          widx_nxt = widx_r + 3'd1;
          state_nxt = ST_RED;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt = flag_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r <= n_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
    t_r <= t_nxt;
    r_r <= r_nxt;
    base_r <= base_nxt;
    widx_r <= widx_nxt;
    large_r <= large_nxt;
    flag_r <= flag_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = {7'd0, out_flag_r};

endmodule

// ===== sim/mrpt_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the primality flag of each accepted number and compares results.
module mrpt_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  output int          fail_count,
  output int          flags_pending
);

  import mrpt_pkg::*;

  localparam logic [NumW-1:0] FewWitLimit = 63'd4759123141;

  logic [63:0] few_wit [3] = '{64'd2, 64'd7, 64'd61};
  logic [63:0] many_wit [7] = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775,
                                64'd9780504, 64'd1795265022};

  logic expected_flags [$];

  function automatic logic [63:0] prod_mod(input logic [63:0] x, input logic [63:0] y,
                                           input logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return 64'(p % {64'd0, m});
  endfunction

  function automatic logic [63:0] power_mod(input logic [63:0] b, input logic [63:0] e,
                                            input logic [63:0] m);
    logic [63:0] r;
    logic [63:0] bb;
    logic [63:0] ee;
    r = 64'd1 % m;
    bb = b % m;
    ee = e;
    while (ee != 0) begin
      if (ee[0]) r = prod_mod(r, bb, m);
      bb = prod_mod(bb, bb, m);
      ee = ee >> 1;
    end
    return r;
  endfunction

  function automatic logic witness_clears(input logic [63:0] a, input logic [63:0] m,
                                          input logic [63:0] d);
    logic [63:0] mm1;
    logic [63:0] t;
    logic [63:0] y;
    logic [63:0] aa;
    mm1 = m - 1;
    t = d;
    aa = a % m;
    if (aa == 0) return 1'b1;
    y = power_mod(aa, t, m);
    while (t != mm1 && y != 1 && y != mm1) begin
      y = prod_mod(y, y, m);
      t = t << 1;
    end
    if (y != mm1 && !t[0]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic predict_prime(input logic [63:0] raw);
    logic [63:0] m;
    logic [63:0] d;
    m = {1'b0, raw[62:0]};
    if (m <= 1) return 1'b0;
    if (m == 2) return 1'b1;
    if (!m[0]) return 1'b0;
    d = m - 1;
    while (!d[0]) d = d >> 1;
    if (m < {1'b0, FewWitLimit}) begin
      foreach (few_wit[i]) if (!witness_clears(few_wit[i], m, d)) return 1'b0;
    end else begin
      foreach (many_wit[i]) if (!witness_clears(many_wit[i], m, d)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign flags_pending = expected_flags.size();

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_flags = {expected_flags, predict_prime(in_tdata)};
      if (out_tvalid && out_tready) begin
        if (expected_flags.size() == 0) begin
          report($sformatf("result beat 0x%02h with no number pending", out_tdata));
        end else begin
          logic want;
          want = expected_flags.pop_front();
          if (out_tdata[0] !== want)
            report($sformatf("is_prime_flag got %b expected %b", out_tdata[0], want));
          if (out_tdata[7:1] !== 7'd0)
            report($sformatf("pad bits got 0x%02h", out_tdata[7:1]));
        end
      end
    end
  end

endmodule

// ===== sim/tb_miller_rabin_prime_test_64_unit.sv =====
`timescale 1ns / 1ps
// Top of the testbench: drives numbers with bursts and gaps, stalls results, gives the verdict.
module tb_miller_rabin_prime_test_64_unit;

  localparam int WatchdogCycles = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  int          fail_count;
  int          flags_pending;
  int          idle_cycles;
  int          burst_left;

  miller_rabin_prime_test_64_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  mrpt_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .flags_pending(flags_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver alternates between free-running stretches and stretches of random stalls.
  int stall_mode;
  int mode_left;
  initial begin
    out_tready = 1'b0;
    stall_mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogCycles) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_number(input logic [63:0] v);
    logic took;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
  endtask

  function automatic logic [63:0] random_number();
    logic [63:0] v;
    int bits;
    v = {$urandom(), $urandom()};
    if ($urandom_range(0, 15) == 0) begin
      bits = 63;
    end else begin
      bits = $urandom_range(2, 34);
    end
    v[62:0] = v[62:0] & ((63'd1 << bits) - 63'd1);
    if ($urandom_range(0, 3) != 0) v[0] = 1'b1;
    return v;
  endfunction

  logic [63:0] directed [] = '{
    64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd7, 64'd9, 64'd61, 64'd25,
    64'd325, 64'd561, 64'd3215031751, 64'd4759123139, 64'd4759123140,
    64'd4759123141, 64'd4759123143, 64'h8000_0000_0000_0003, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE, 64'd2305843009213693951,
    64'd9223372036854775783, 64'd1000000000000000003
  };

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_number(directed[i]);
    repeat (116) send_number(random_number());
    in_tvalid <= 1'b0;
    while (flags_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
